// ----- rtl/owm_pkg.sv -----
package owm_pkg;

	localparam int unsigned TickW  = 10;
	localparam int unsigned BitW   = 3;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned CmdW   = 3;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 10;
	localparam int unsigned InDataW  = 16;
	localparam int unsigned OutDataW = 16;

	localparam logic [CmdW-1:0] CMD_RESET = 3'd0;
	localparam logic [CmdW-1:0] CMD_WBIT  = 3'd1;
	localparam logic [CmdW-1:0] CMD_RBIT  = 3'd2;
	localparam logic [CmdW-1:0] CMD_WBYTE = 3'd3;
	localparam logic [CmdW-1:0] CMD_RBYTE = 3'd4;

	localparam logic [CfgIdxW-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_RESET_TAIL    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_GAP           = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_WRITE_SHORT   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_WRITE_LONG    = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_READ_SAMPLE   = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_READ_TAIL     = 3'd7;

	localparam logic [BitW-1:0] LAST_BIT = 3'd7;

	typedef enum logic [9:0] {
		PH_IDLE     = 10'b00_0000_0001,
		PH_RST_LOW  = 10'b00_0000_0010,
		PH_RST_WAIT = 10'b00_0000_0100,
		PH_RST_TAIL = 10'b00_0000_1000,
		PH_GAP      = 10'b00_0001_0000,
		PH_WLOW     = 10'b00_0010_0000,
		PH_WREL     = 10'b00_0100_0000,
		PH_RLOW     = 10'b00_1000_0000,
		PH_RWAIT    = 10'b01_0000_0000,
		PH_RTAIL    = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic [9:0] reset_low;
		logic [7:0] presence_wait;
		logic [9:0] reset_tail;
		logic [3:0] gap;
		logic [3:0] write_short;
		logic [6:0] write_long;
		logic [5:0] read_sample;
		logic [6:0] read_tail;
	} cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic [TickW-1:0]  tick;
		logic [BitW-1:0]   bits;
		logic [ByteW-1:0]  shift;
		logic [CmdW-1:0]   cmd;
	} state_t;

	typedef struct packed {
		logic             start_req;
		logic [CmdW-1:0]  command;
		logic [ByteW-1:0] data;
		logic             line_in;
	} tick_in_t;

	typedef struct packed {
		logic             drive_low;
		logic             busy_res;
		logic             done_res;
		logic [ByteW-1:0] result_data;
	} tick_out_t;

endpackage

// ----- rtl/one_wire_bus_master_unit.sv -----
// The result of an accepted tick is registered and is on m_tdata in the next cycle.
// Throughput: one tick per cycle; the phase/slot step is a single registered
// pass from the state register to the result register. A held result stalls
// the input side only while m_tready is low.
// Reset (arst_n low, asynchronous): phase idle, counters and shift cleared,
// timing registers back to their defaults, no result pending.
module one_wire_bus_master_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [0] start_req, [3:1] command, [11:4] data, [12] line_in, [15:13] zero
	input  logic [owm_pkg::InDataW-1:0]      s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] drive_low, [1] busy_res, [2] done_res, [10:3] result_data, [15:11] zero
	output logic [owm_pkg::OutDataW-1:0]     m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [owm_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [owm_pkg::CfgDataW-1:0]     cfg_data
);

	owm_pkg::cfg_t      cfg;
	owm_pkg::state_t    state_q;
	owm_pkg::state_t    state_nxt;
	owm_pkg::tick_in_t  tin;
	owm_pkg::tick_out_t tout;
	owm_pkg::tick_out_t res_q;
	logic               res_valid_q;
	logic               in_xfer;

	assign cfg_ready = 1'b1;

	owm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign tin.start_req = s_tdata[0];
	assign tin.command   = s_tdata[3:1];
	assign tin.data      = s_tdata[11:4];
	assign tin.line_in   = s_tdata[12];

	owm_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.tin  (tin),
		.nxt  (state_nxt),
		.tout (tout)
	);

	// next tick is taken whenever the result slot is empty or draining
	assign s_tready = !res_valid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= owm_pkg::PH_IDLE;
			state_q.tick  <= '0;
			state_q.bits  <= '0;
			state_q.shift <= '0;
			state_q.cmd   <= owm_pkg::CMD_RESET;
			res_valid_q   <= 1'b0;
		end else begin
			if (in_xfer) begin
				state_q <= state_nxt;
			end
			if (in_xfer) begin
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q <= tout;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {5'b0, res_q.result_data, res_q.done_res, res_q.busy_res,
	                   res_q.drive_low};

endmodule

// ----- rtl/owm_cfg.sv -----
module owm_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [owm_pkg::CfgIdxW-1:0]     wr_index,
	input  logic [owm_pkg::CfgDataW-1:0]    wr_data,
	output owm_pkg::cfg_t                   cfg
);

	owm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low     <= 10'd500;
			cfg_q.presence_wait <= 8'd100;
			cfg_q.reset_tail    <= 10'd400;
			cfg_q.gap           <= 4'd2;
			cfg_q.write_short   <= 4'd4;
			cfg_q.write_long    <= 7'd64;
			cfg_q.read_sample   <= 6'd15;
			cfg_q.read_tail     <= 7'd60;
		end else if (wr_en) begin
			unique case (wr_index)
				owm_pkg::REG_RESET_LOW:     cfg_q.reset_low     <= wr_data;
				owm_pkg::REG_PRESENCE_WAIT: cfg_q.presence_wait <= wr_data[7:0];
				owm_pkg::REG_RESET_TAIL:    cfg_q.reset_tail    <= wr_data;
				owm_pkg::REG_GAP:           cfg_q.gap           <= wr_data[3:0];
				owm_pkg::REG_WRITE_SHORT:   cfg_q.write_short   <= wr_data[3:0];
				owm_pkg::REG_WRITE_LONG:    cfg_q.write_long    <= wr_data[6:0];
				owm_pkg::REG_READ_SAMPLE:   cfg_q.read_sample   <= wr_data[5:0];
				owm_pkg::REG_READ_TAIL:     cfg_q.read_tail     <= wr_data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/owm_step.sv -----
module owm_step (
	input  owm_pkg::cfg_t      cfg,
	input  owm_pkg::state_t    cur,
	input  owm_pkg::tick_in_t  tin,
	output owm_pkg::state_t    nxt,
	output owm_pkg::tick_out_t tout
);

	owm_pkg::state_t               st;
	logic [owm_pkg::TickW-1:0]     raw_len;
	logic [owm_pkg::TickW-1:0]     len;
	logic                          is_write;

	always_comb begin
		st   = cur;
		tout = '0;

		// a start is taken only from idle and only for a known command
		if (cur.phase == owm_pkg::PH_IDLE && tin.start_req &&
		    tin.command <= owm_pkg::CMD_RBYTE) begin
			st.cmd   = tin.command;
			st.bits  = '0;
			st.tick  = '0;
			st.shift = (tin.command == owm_pkg::CMD_WBIT ||
			            tin.command == owm_pkg::CMD_WBYTE) ? tin.data : '0;
			st.phase = (tin.command == owm_pkg::CMD_RESET) ?
			           owm_pkg::PH_RST_LOW : owm_pkg::PH_GAP;
		end

		is_write = (st.cmd == owm_pkg::CMD_WBIT || st.cmd == owm_pkg::CMD_WBYTE);

		unique case (st.phase) inside
			owm_pkg::PH_RST_LOW:  raw_len = cfg.reset_low;
			owm_pkg::PH_RST_WAIT: raw_len = {2'b0, cfg.presence_wait};
			owm_pkg::PH_RST_TAIL: raw_len = cfg.reset_tail;
			owm_pkg::PH_GAP,
			owm_pkg::PH_RLOW:     raw_len = {6'b0, cfg.gap};
			owm_pkg::PH_WLOW:     raw_len = st.shift[0] ? {6'b0, cfg.write_short}
			                                            : {3'b0, cfg.write_long};
			owm_pkg::PH_WREL:     raw_len = st.shift[0] ? {3'b0, cfg.write_long}
			                                            : {6'b0, cfg.write_short};
			owm_pkg::PH_RWAIT:    raw_len = {4'b0, cfg.read_sample};
			default:              raw_len = {3'b0, cfg.read_tail};
		endcase
		// a zero length still takes one tick
		len = (raw_len == '0) ? owm_pkg::TickW'(1) : raw_len;

		if (st.phase != owm_pkg::PH_IDLE) begin
			tout.busy_res  = 1'b1;
			tout.drive_low = (st.phase == owm_pkg::PH_RST_LOW ||
			                  st.phase == owm_pkg::PH_WLOW ||
			                  st.phase == owm_pkg::PH_RLOW);
			st.tick = st.tick + owm_pkg::TickW'(1);
			if (st.tick >= len) begin
				st.tick = '0;
				unique case (st.phase)
					owm_pkg::PH_RST_LOW:  st.phase = owm_pkg::PH_RST_WAIT;
					owm_pkg::PH_RST_WAIT: begin
						st.shift = {7'b0, tin.line_in};
						st.phase = owm_pkg::PH_RST_TAIL;
					end
					owm_pkg::PH_RST_TAIL: begin
						tout.done_res    = 1'b1;
						tout.result_data = {7'b0, st.shift[0]};
						st.phase         = owm_pkg::PH_IDLE;
					end
					owm_pkg::PH_GAP:  st.phase = is_write ? owm_pkg::PH_WLOW
					                                      : owm_pkg::PH_RLOW;
					owm_pkg::PH_WLOW: st.phase = owm_pkg::PH_WREL;
					owm_pkg::PH_WREL: begin
						if (st.cmd == owm_pkg::CMD_WBYTE && st.bits != owm_pkg::LAST_BIT) begin
							st.bits  = st.bits + owm_pkg::BitW'(1);
							st.shift = {1'b0, st.shift[7:1]};
							st.phase = owm_pkg::PH_GAP;
						end else begin
							tout.done_res = 1'b1;
							st.phase      = owm_pkg::PH_IDLE;
						end
					end
					owm_pkg::PH_RLOW:  st.phase = owm_pkg::PH_RWAIT;
					owm_pkg::PH_RWAIT: begin
						st.shift = {tin.line_in, st.shift[7:1]};
						st.phase = owm_pkg::PH_RTAIL;
					end
					owm_pkg::PH_RTAIL: begin
						if (st.cmd == owm_pkg::CMD_RBYTE && st.bits != owm_pkg::LAST_BIT) begin
							st.bits  = st.bits + owm_pkg::BitW'(1);
							st.phase = owm_pkg::PH_GAP;
						end else begin
							tout.done_res    = 1'b1;
							tout.result_data = (st.cmd == owm_pkg::CMD_RBYTE) ? st.shift
							                   : {7'b0, st.shift[7]};
							st.phase         = owm_pkg::PH_IDLE;
						end
					end
					default: st.phase = owm_pkg::PH_IDLE;
				endcase
			end
		end

		nxt = st;
	end

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int LINE_LOW  = 0;
	localparam int LINE_HIGH = 1;
	localparam int LINE_RAND = 2;

	// timing registers as they come out of reset
	localparam owm_pkg::cfg_t TIMING_DEFAULT = '{
		reset_low: 10'd500, presence_wait: 8'd100, reset_tail: 10'd400, gap: 4'd2,
		write_short: 4'd4, write_long: 7'd64, read_sample: 6'd15, read_tail: 7'd60
	};

	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	// [0] start_req, [3:1] command, [11:4] data, [12] line_in, [15:13] zero
	logic [owm_pkg::InDataW-1:0]   s_tdata   = '0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	// [0] drive_low, [1] busy_res, [2] done_res, [10:3] result_data, [15:11] zero
	logic [owm_pkg::OutDataW-1:0]  m_tdata;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [owm_pkg::CfgIdxW-1:0]   cfg_index = '0;
	logic [owm_pkg::CfgDataW-1:0]  cfg_data  = '0;

	one_wire_bus_master_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// bus master shadow state
	owm_pkg::phase_t           ph       = owm_pkg::PH_IDLE;
	logic [owm_pkg::TickW-1:0] tick_cnt = '0;
	logic [2:0]                bit_cnt  = '0;
	logic [7:0]                shreg    = '0;
	logic [2:0]                act_cmd  = '0;
	owm_pkg::cfg_t             timing   = TIMING_DEFAULT;

	owm_pkg::tick_out_t pending_bus_outputs[$];
	int unsigned src_idle_pct  = 34;
	int unsigned snk_stall_pct = 84;
	int unsigned fail_count    = 0;
	int unsigned ticks_sent    = 0;
	int unsigned outputs_seen  = 0;
	int unsigned cycle_count   = 0;
	int unsigned ops_done[5]   = '{default: 0};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("one_wire_bus_master_unit verification failed");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= snk_stall_pct);

	function automatic owm_pkg::tick_out_t onewire_step(input logic start,
			input logic [2:0] cmd, input logic [7:0] data, input logic line);
		owm_pkg::tick_out_t        o;
		logic [owm_pkg::TickW-1:0] len;
		o = '0;
		if (ph == owm_pkg::PH_IDLE && start && cmd <= owm_pkg::CMD_RBYTE) begin
			act_cmd  = cmd;
			bit_cnt  = '0;
			tick_cnt = '0;
			shreg    = (cmd == owm_pkg::CMD_WBIT || cmd == owm_pkg::CMD_WBYTE) ? data : 8'h00;
			if (cmd == owm_pkg::CMD_RESET)
				ph = owm_pkg::PH_RST_LOW;
			else
				ph = owm_pkg::PH_GAP;
		end
		if (ph != owm_pkg::PH_IDLE) begin
			o.busy_res  = 1'b1;
			o.drive_low = (ph == owm_pkg::PH_RST_LOW || ph == owm_pkg::PH_WLOW ||
			               ph == owm_pkg::PH_RLOW);
			tick_cnt    = tick_cnt + owm_pkg::TickW'(1);
			case (ph) inside
				owm_pkg::PH_RST_LOW:  len = timing.reset_low;
				owm_pkg::PH_RST_WAIT: len = owm_pkg::TickW'(timing.presence_wait);
				owm_pkg::PH_RST_TAIL: len = timing.reset_tail;
				owm_pkg::PH_GAP,
				owm_pkg::PH_RLOW:     len = owm_pkg::TickW'(timing.gap);
				owm_pkg::PH_WLOW:     len = shreg[0] ? owm_pkg::TickW'(timing.write_short)
				                                     : owm_pkg::TickW'(timing.write_long);
				owm_pkg::PH_WREL:     len = shreg[0] ? owm_pkg::TickW'(timing.write_long)
				                                     : owm_pkg::TickW'(timing.write_short);
				owm_pkg::PH_RWAIT:    len = owm_pkg::TickW'(timing.read_sample);
				default:              len = owm_pkg::TickW'(timing.read_tail);
			endcase
			// a zero register still gives a one-tick phase
			if (len == '0)
				len = owm_pkg::TickW'(1);
			if (tick_cnt >= len) begin
				tick_cnt = '0;
				case (ph)
					owm_pkg::PH_RST_LOW: ph = owm_pkg::PH_RST_WAIT;
					owm_pkg::PH_RST_WAIT: begin
						shreg = {7'b0, line};
						ph    = owm_pkg::PH_RST_TAIL;
					end
					owm_pkg::PH_RST_TAIL: begin
						o.done_res    = 1'b1;
						o.result_data = {7'b0, shreg[0]};
						ph            = owm_pkg::PH_IDLE;
					end
					owm_pkg::PH_GAP: begin
						if (act_cmd == owm_pkg::CMD_WBIT || act_cmd == owm_pkg::CMD_WBYTE)
							ph = owm_pkg::PH_WLOW;
						else
							ph = owm_pkg::PH_RLOW;
					end
					owm_pkg::PH_WLOW: ph = owm_pkg::PH_WREL;
					owm_pkg::PH_WREL: begin
						if (act_cmd == owm_pkg::CMD_WBYTE && bit_cnt < owm_pkg::LAST_BIT) begin
							bit_cnt++;
							shreg = shreg >> 1;
							ph    = owm_pkg::PH_GAP;
						end else begin
							o.done_res = 1'b1;
							ph         = owm_pkg::PH_IDLE;
						end
					end
					owm_pkg::PH_RLOW: ph = owm_pkg::PH_RWAIT;
					owm_pkg::PH_RWAIT: begin
						shreg = {line, shreg[7:1]};
						ph    = owm_pkg::PH_RTAIL;
					end
					default: begin
						if (act_cmd == owm_pkg::CMD_RBYTE && bit_cnt < owm_pkg::LAST_BIT) begin
							bit_cnt++;
							ph = owm_pkg::PH_GAP;
						end else begin
							o.done_res    = 1'b1;
							o.result_data = (act_cmd == owm_pkg::CMD_RBYTE) ? shreg
							                : {7'b0, shreg[7]};
							ph            = owm_pkg::PH_IDLE;
						end
					end
				endcase
				if (o.done_res)
					ops_done[act_cmd]++;
			end
		end
		return o;
	endfunction

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		owm_pkg::tick_out_t want;
		owm_pkg::tick_out_t got;
		if (arst_n && m_tvalid && m_tready) begin
			outputs_seen++;
			got.drive_low   = m_tdata[0];
			got.busy_res    = m_tdata[1];
			got.done_res    = m_tdata[2];
			got.result_data = m_tdata[10:3];
			if (pending_bus_outputs.size() == 0) begin
				log_failure($sformatf("output transfer %0h with nothing outstanding", m_tdata));
			end else begin
				want = pending_bus_outputs.pop_front();
				if (got.drive_low != want.drive_low || got.busy_res != want.busy_res ||
						got.done_res != want.done_res || got.result_data != want.result_data)
					log_failure($sformatf({"output %0d: expected drive %0b busy %0b done %0b ",
						"data %02h, got drive %0b busy %0b done %0b data %02h"}, outputs_seen,
						want.drive_low, want.busy_res, want.done_res, want.result_data,
						got.drive_low, got.busy_res, got.done_res, got.result_data));
			end
		end
	end

	task automatic send_tick(input logic start, input logic [2:0] cmd, input logic [7:0] data,
			input logic line);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, line, data, cmd, start};
		do @(posedge clk); while (!s_tready);
		pending_bus_outputs.push_back(onewire_step(start, cmd, data, line));
		ticks_sent++;
	endtask

	function automatic logic pick_line(input int mode);
		if (mode == LINE_RAND)
			return 1'($urandom_range(1));
		return (mode == LINE_HIGH);
	endfunction

	// one operation from its start tick to completion; starts while busy are noise
	task automatic run_op(input logic [2:0] cmd, input logic [7:0] data, input int line_mode);
		send_tick(1'b1, cmd, data, pick_line(line_mode));
		while (ph != owm_pkg::PH_IDLE)
			send_tick(1'($urandom_range(1)), 3'($urandom_range(7)), 8'($urandom),
				pick_line(line_mode));
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_bus_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timing(input owm_pkg::cfg_t c);
		for (int i = 0; i < 8; i++) begin
			logic [owm_pkg::CfgIdxW-1:0]  idx;
			logic [owm_pkg::CfgDataW-1:0] val;
			idx = owm_pkg::CfgIdxW'(i);
			case (idx)
				owm_pkg::REG_RESET_LOW:     val = c.reset_low;
				owm_pkg::REG_PRESENCE_WAIT: val = owm_pkg::CfgDataW'(c.presence_wait);
				owm_pkg::REG_RESET_TAIL:    val = c.reset_tail;
				owm_pkg::REG_GAP:           val = owm_pkg::CfgDataW'(c.gap);
				owm_pkg::REG_WRITE_SHORT:   val = owm_pkg::CfgDataW'(c.write_short);
				owm_pkg::REG_WRITE_LONG:    val = owm_pkg::CfgDataW'(c.write_long);
				owm_pkg::REG_READ_SAMPLE:   val = owm_pkg::CfgDataW'(c.read_sample);
				default:                    val = owm_pkg::CfgDataW'(c.read_tail);
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		timing = c;
	endtask

	function automatic owm_pkg::cfg_t quick_timing();
		owm_pkg::cfg_t c;
		c.reset_low     = 10'($urandom_range(0, 6));
		c.presence_wait = 8'($urandom_range(0, 5));
		c.reset_tail    = 10'($urandom_range(0, 6));
		c.gap           = 4'($urandom_range(0, 3));
		c.write_short   = 4'($urandom_range(0, 3));
		c.write_long    = 7'($urandom_range(1, 8));
		c.read_sample   = 6'($urandom_range(0, 4));
		c.read_tail     = 7'($urandom_range(0, 5));
		return c;
	endfunction

	// slot timings straight out of reset
	task automatic test_default_timing();
		run_op(owm_pkg::CMD_WBIT, 8'h01, LINE_RAND);
		run_op(owm_pkg::CMD_RBIT, 8'hFF, LINE_HIGH);
		settle();
	endtask

	task automatic test_ignored_starts();
		send_tick(1'b1, 3'd5, 8'hFF, 1'b1);
		send_tick(1'b1, 3'd6, 8'h00, 1'b0);
		send_tick(1'b1, 3'd7, 8'hAA, 1'b1);
		send_tick(1'b0, owm_pkg::CMD_RESET, 8'h55, 1'b0);
		send_tick(1'b0, owm_pkg::CMD_RBYTE, 8'hFF, 1'b1);
		settle();
	endtask

	// every phase one tick long; operations run back to back
	task automatic test_zero_timing();
		write_timing('0);
		run_op(owm_pkg::CMD_RESET, 8'h00, LINE_HIGH);
		run_op(owm_pkg::CMD_RESET, 8'hFF, LINE_LOW);
		run_op(owm_pkg::CMD_WBIT, 8'h00, LINE_RAND);
		run_op(owm_pkg::CMD_WBIT, 8'hFF, LINE_RAND);
		run_op(owm_pkg::CMD_RBIT, 8'h00, LINE_LOW);
		run_op(owm_pkg::CMD_WBYTE, 8'hA5, LINE_RAND);
		run_op(owm_pkg::CMD_RBYTE, 8'hFF, LINE_RAND);
		settle();
	endtask

	// full-scale gap and write slot registers
	task automatic test_max_timing();
		write_timing('1);
		run_op(owm_pkg::CMD_WBIT, 8'h01, LINE_RAND);
		settle();
	endtask

	task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
			input int unsigned n, input bit drain_midway);
		int unsigned r;
		write_timing(quick_timing());
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		for (int unsigned i = 0; i < n; i++) begin
			if (drain_midway && i == n / 2)
				settle();
			r = $urandom_range(99);
			if (ph == owm_pkg::PH_IDLE) begin
				// mostly legal starts, some bad commands and quiet ticks
				if (r < 80)
					send_tick(1'b1, 3'($urandom_range(owm_pkg::CMD_RESET, owm_pkg::CMD_RBYTE)),
						8'($urandom), 1'($urandom_range(1)));
				else if (r < 90)
					send_tick(1'b1, 3'($urandom_range(5, 7)), 8'($urandom),
						1'($urandom_range(1)));
				else
					send_tick(1'b0, 3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)));
			end else begin
				send_tick(1'(r < 50), 3'($urandom_range(7)), 8'($urandom),
					1'($urandom_range(1)));
			end
		end
		while (ph != owm_pkg::PH_IDLE)
			send_tick(1'($urandom_range(1)), 3'($urandom_range(7)), 8'($urandom),
				1'($urandom_range(1)));
		settle();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_timing();
		test_ignored_starts();
		test_zero_timing();
		test_max_timing();
		test_random_traffic(34, 84, 80, 1'b1);
		test_random_traffic(84, 34, 80, 1'b0);
		test_random_traffic(0, 0, 80, 1'b0);
		repeat (10) @(posedge clk);
		$display("Covered %0d bus ticks, %0d results checked; reset, zero, full-scale",
			ticks_sent, outputs_seen);
		$display("and random slot timings; done: reset %0d wbit %0d rbit %0d wbyte %0d rbyte %0d",
			ops_done[owm_pkg::CMD_RESET], ops_done[owm_pkg::CMD_WBIT],
			ops_done[owm_pkg::CMD_RBIT], ops_done[owm_pkg::CMD_WBYTE],
			ops_done[owm_pkg::CMD_RBYTE]);
		if (fail_count == 0 && pending_bus_outputs.size() == 0) begin
			$display("one_wire_bus_master_unit verification clean");
		end else begin
			$display("one_wire_bus_master_unit verification failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/owm_pkg.sv
rtl/owm_cfg.sv
rtl/owm_step.sv
rtl/one_wire_bus_master_unit.sv
tb/sv/tb_top.sv
